// ----- design/ckw_pkg.sv -----
// ckw_pkg: shared constants, types and the sorted keyword table for c_keyword_counter.
// Used by ckw_lexer and c_keyword_counter. Depends on nothing.
package ckw_pkg;

    localparam int CHAR_W     = 8;
    localparam int KEY_W      = 64;   // eight characters, first character in the top byte
    localparam int TABLE_SIZE = 31;   // keywords held in the table
    localparam int KW_IDX_W   = 5;    // keyword_index field width
    localparam int HIT_W      = 16;   // hit_count field width

    // defaults for the top-level parameters
    localparam int NUM_KEYWORDS_DEF  = 31;
    localparam int MAX_KEY_CHARS_DEF = 8;
    localparam int COUNT_BITS_DEF    = 16;

    // characters the lexer reacts to
    localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 8'h5F;  // '_'
    localparam logic [CHAR_W-1:0] CH_HASH       = 8'h23;  // '#'
    localparam logic [CHAR_W-1:0] CH_SLASH      = 8'h2F;  // '/'
    localparam logic [CHAR_W-1:0] CH_STAR       = 8'h2A;  // '*'
    localparam logic [CHAR_W-1:0] CH_NEWLINE    = 8'h0A;  // '\n'
    localparam logic [CHAR_W-1:0] CH_SQUOTE     = 8'h27;  // single quote
    localparam logic [CHAR_W-1:0] CH_DQUOTE     = 8'h22;  // double quote
    localparam logic [CHAR_W-1:0] CH_SPACE      = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB        = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR         = 8'h0D;

    // lookup request from the lexer: a finished word that may be a keyword
    typedef struct packed {
        logic             go;
        logic [KEY_W-1:0] key;
    } t_lookup;

    // Keyword table, left-aligned and zero padded, so that a numeric compare
    // gives dictionary order.
    function automatic logic [KEY_W-1:0] kw_key(input logic [KW_IDX_W-1:0] idx);
        logic [KEY_W-1:0] k;
        case (idx)
            5'd0:    k = {"auto",     32'h0};
            5'd1:    k = {"break",    24'h0};
            5'd2:    k = {"case",     32'h0};
            5'd3:    k = {"char",     32'h0};
            5'd4:    k = {"const",    24'h0};
            5'd5:    k = "continue";
            5'd6:    k = {"default",   8'h0};
            5'd7:    k = {"define",   16'h0};
            5'd8:    k = {"do",       48'h0};
            5'd9:    k = {"double",   16'h0};
            5'd10:   k = {"else",     32'h0};
            5'd11:   k = {"enum",     32'h0};
            5'd12:   k = {"extern",   16'h0};
            5'd13:   k = {"float",    24'h0};
            5'd14:   k = {"for",      40'h0};
            5'd15:   k = {"goto",     32'h0};
            5'd16:   k = {"if",       48'h0};
            5'd17:   k = {"int",      40'h0};
            5'd18:   k = {"long",     32'h0};
            5'd19:   k = "register";
            5'd20:   k = {"return",   16'h0};
            5'd21:   k = {"short",    24'h0};
            5'd22:   k = {"signed",   16'h0};
            5'd23:   k = {"static",   16'h0};
            5'd24:   k = {"struct",   16'h0};
            5'd25:   k = {"switch",   16'h0};
            5'd26:   k = {"typedef",   8'h0};
            5'd27:   k = "unsigned";
            5'd28:   k = {"void",     32'h0};
            5'd29:   k = "volatile";
            5'd30:   k = {"while",    24'h0};
            default: k = '0;
        endcase
        return k;
    endfunction

endpackage

// ----- design/ckw_lexer.sv -----
// ckw_lexer: character-level tokenizer for c_keyword_counter; one character per step.
// Tracks comments, words and '#', and hands out finished words for lookup.
// Depends on ckw_pkg.
module ckw_lexer #(
    parameter int MAX_KEY_CHARS = ckw_pkg::MAX_KEY_CHARS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic [ckw_pkg::CHAR_W-1:0]  i_char,
    input  logic                        i_eot,
    output ckw_pkg::t_lookup            o_lookup
);

    localparam int LEN_W = $clog2(MAX_KEY_CHARS + 1);

    // lexer modes
    localparam logic [2:0] M_NORMAL     = 3'd0;
    localparam logic [2:0] M_WORD       = 3'd1;
    localparam logic [2:0] M_SLASH      = 3'd2;
    localparam logic [2:0] M_LINE       = 3'd3;
    localparam logic [2:0] M_BLOCK      = 3'd4;
    localparam logic [2:0] M_BLOCK_STAR = 3'd5;
    localparam logic [2:0] M_HASH       = 3'd6;

    logic [2:0]                 r_mode, n_mode;
    logic [ckw_pkg::KEY_W-1:0]  r_word, n_word;
    logic [LEN_W-1:0]           r_len,  n_len;
    logic                       r_unm,  n_unm;

    logic is_letter, is_digit, is_wc, is_space, is_quote;
    logic finish;

    // character classes
    always_comb begin
        is_letter = (i_char >= 8'h61 && i_char <= 8'h7A) || (i_char >= 8'h41 && i_char <= 8'h5A);
        is_digit  = (i_char >= 8'h30 && i_char <= 8'h39);
        is_wc     = is_letter || is_digit || (i_char == ckw_pkg::CH_UNDERSCORE);
        is_space  = (i_char == ckw_pkg::CH_SPACE) ||
                    (i_char >= ckw_pkg::CH_TAB && i_char <= ckw_pkg::CH_CR);
        is_quote  = (i_char == ckw_pkg::CH_SQUOTE) || (i_char == ckw_pkg::CH_DQUOTE);
    end

    // next lexer state; a word end or a lone slash falls through to normal handling
    always_comb begin
        logic do_normal;
        do_normal = 1'b0;
        finish    = 1'b0;
        n_mode    = r_mode;
        n_word    = r_word;
        n_len     = r_len;
        n_unm     = r_unm;
        case (r_mode)
            M_WORD: begin
                if (is_wc) begin
                    if (r_len < LEN_W'(MAX_KEY_CHARS)) begin
                        n_word[ckw_pkg::KEY_W-1 - ckw_pkg::CHAR_W*int'(3'(r_len)) -: ckw_pkg::CHAR_W]
                            = i_char;
                        n_len = r_len + 1'b1;
                    end else begin
                        n_unm = 1'b1;
                    end
                end else begin
                    finish    = 1'b1;
                    n_word    = '0;
                    n_len     = '0;
                    n_unm     = 1'b0;
                    do_normal = 1'b1;
                end
            end
            M_SLASH: begin
                if (i_char == ckw_pkg::CH_SLASH) begin
                    n_mode = M_LINE;
                end else if (i_char == ckw_pkg::CH_STAR) begin
                    n_mode = M_BLOCK;
                end else begin
                    do_normal = 1'b1;
                end
            end
            M_LINE: begin
                if (i_char == ckw_pkg::CH_NEWLINE) n_mode = M_NORMAL;
            end
            M_BLOCK: begin
                if (i_char == ckw_pkg::CH_STAR) n_mode = M_BLOCK_STAR;
            end
            M_BLOCK_STAR: begin
                if (i_char == ckw_pkg::CH_SLASH) begin
                    n_mode = M_NORMAL;
                end else if (i_char != ckw_pkg::CH_STAR) begin
                    n_mode = M_BLOCK;
                end
            end
            M_HASH: begin
                if (is_letter || is_quote) begin
                    n_mode = M_WORD;
                    n_word = {i_char, {(ckw_pkg::KEY_W-ckw_pkg::CHAR_W){1'b0}}};
                    n_len  = LEN_W'(1);
                    n_unm  = is_quote;
                end else begin
                    n_mode = M_NORMAL;
                end
            end
            default: begin
                do_normal = 1'b1;
            end
        endcase

        // handling between tokens
        if (do_normal) begin
            n_mode = M_NORMAL;
            if (is_space) begin
                n_mode = M_NORMAL;
            end else if (i_char == ckw_pkg::CH_SLASH) begin
                n_mode = M_SLASH;
            end else if (i_char == ckw_pkg::CH_HASH) begin
                n_mode = M_HASH;
            end else if (is_letter || is_quote) begin
                n_mode = M_WORD;
                n_word = {i_char, {(ckw_pkg::KEY_W-ckw_pkg::CHAR_W){1'b0}}};
                n_len  = LEN_W'(1);
                n_unm  = is_quote;
            end
        end
    end

    // Lookup request. A character that ends a word can only open a quoted
    // word, so at most one word per character needs a lookup.
    always_comb begin
        o_lookup.go  = 1'b0;
        o_lookup.key = r_word;
        if (finish) begin
            o_lookup.go = !r_unm;
        end else if (i_eot && n_mode == M_WORD) begin
            o_lookup.go  = !n_unm;
            o_lookup.key = n_word;
        end
    end

    // state registers; end of text returns the lexer to its reset state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_NORMAL;
            r_word <= '0;
            r_len  <= '0;
            r_unm  <= 1'b0;
        end else if (i_step) begin
            if (i_eot) begin
                r_mode <= M_NORMAL;
                r_word <= '0;
                r_len  <= '0;
                r_unm  <= 1'b0;
            end else begin
                r_mode <= n_mode;
                r_word <= n_word;
                r_len  <= n_len;
                r_unm  <= n_unm;
            end
        end
    end

endmodule

// ----- design/c_keyword_counter.sv -----
// c_keyword_counter: top level. Counts C keywords in a character stream and
// reports the counts at end of text. Depends on ckw_pkg and ckw_lexer.
//
// Usage
//   Slave channel: one source character per item in tdata, tlast on the final
//   character of the text. Master channel: one item per keyword seen, in table
//   order, with tdata = {hit_count, keyword_index}; tuser flags the single item
//   sent when no keyword was seen; tlast marks the final item of the report.
// Timing
//   A character that closes a candidate word is followed by a binary search of the
//   sorted table through one 64-bit comparator. At end of text the report
//   sweeps the count registers one entry per cycle up to the last nonzero
//   entry, each emitted item also waiting for a free output register; the
//   input is not ready during search and report.
// Reset
//   Synchronous, active low: lexer to normal, all counts zero, output empty.
// Stall
//   The output register holds its item while tready is low; the sweep waits.
module c_keyword_counter #(
    parameter int NUM_KEYWORDS  = ckw_pkg::NUM_KEYWORDS_DEF,
    parameter int MAX_KEY_CHARS = ckw_pkg::MAX_KEY_CHARS_DEF,
    parameter int COUNT_BITS    = ckw_pkg::COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] char_code
    input  logic        i_s_axis_tlast,   // end_of_text
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [4:0] keyword_index, [20:5] hit_count, rest zero
    output logic        o_m_axis_tuser,   // none_found
    output logic        o_m_axis_tlast    // last_report
);

    localparam int NUM_ENTRIES = (NUM_KEYWORDS < ckw_pkg::TABLE_SIZE) ?
                                 NUM_KEYWORDS : ckw_pkg::TABLE_SIZE;
    localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

    // sequencer states
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_REPORT = 2'd2;

    logic [1:0]                r_state, n_state;
    logic [IDX_W-1:0]          r_lo, n_lo, r_hi, n_hi, r_addr, n_addr;
    logic [ckw_pkg::KEY_W-1:0] r_key;
    logic                      r_eot;
    logic [COUNT_BITS-1:0]     r_cnt [NUM_ENTRIES];
    logic [NUM_ENTRIES-1:0]    r_nz;
    logic                      r_out_valid;
    logic [ckw_pkg::KW_IDX_W-1:0] r_out_idx;
    logic [ckw_pkg::HIT_W-1:0] r_out_hit;
    logic                      r_out_none, r_out_last;

    ckw_pkg::t_lookup          lookup;
    logic                      accept;
    logic [IDX_W:0]            mid_sum;
    logic [IDX_W-1:0]          mid, rd_addr;
    logic [ckw_pkg::KEY_W-1:0] tbl_key;
    logic                      key_eq, key_lt;
    logic [COUNT_BITS-1:0]     cnt_rd;
    logic [31:0]               cnt_ext;
    logic                      cnt_inc, cnt_clr;
    logic [NUM_ENTRIES-1:0]    nz_above;
    logic                      rep_last, out_free, emit, emit_none;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    ckw_lexer #(
        .MAX_KEY_CHARS (MAX_KEY_CHARS)
    ) u_lexer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (accept),
        .i_char   (i_s_axis_tdata),
        .i_eot    (i_s_axis_tlast),
        .o_lookup (lookup)
    );

    // shared comparator: probe the middle of the remaining table range
    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid     = mid_sum[IDX_W:1];
    assign tbl_key = ckw_pkg::kw_key(ckw_pkg::KW_IDX_W'(mid));
    assign key_eq  = (r_key == tbl_key);
    assign key_lt  = (r_key < tbl_key);

    // single read port on the counts
    assign rd_addr = (r_state == S_SEARCH) ? mid : r_addr;
    assign cnt_rd  = r_cnt[rd_addr];
    assign cnt_ext = 32'(cnt_rd);

    // nonzero entries past the current sweep position
    always_comb begin
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            nz_above[i] = r_nz[i] && (i > int'(r_addr));
        end
    end
    assign rep_last = (nz_above == '0);
    assign out_free = !r_out_valid || i_m_axis_tready;

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_addr    = r_addr;
        cnt_inc   = 1'b0;
        cnt_clr   = 1'b0;
        emit      = 1'b0;
        emit_none = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_lo   = '0;
                    n_hi   = IDX_W'(NUM_ENTRIES - 1);
                    n_addr = '0;
                    if (lookup.go) begin
                        n_state = S_SEARCH;
                    end else if (i_s_axis_tlast) begin
                        n_state = S_REPORT;
                    end
                end
            end
            S_SEARCH: begin
                if (key_eq || (key_lt && mid == r_lo) || (!key_lt && mid == r_hi)) begin
                    cnt_inc = key_eq && (cnt_rd != {COUNT_BITS{1'b1}});
                    n_addr  = '0;
                    n_state = r_eot ? S_REPORT : S_IDLE;
                end else if (key_lt) begin
                    n_hi = mid - 1'b1;
                end else begin
                    n_lo = mid + 1'b1;
                end
            end
            S_REPORT: begin
                if (r_nz == '0) begin
                    if (out_free) begin
                        emit_none = 1'b1;
                        n_state   = S_IDLE;
                    end
                end else if (!r_nz[r_addr]) begin
                    n_addr = r_addr + 1'b1;
                end else if (out_free) begin
                    emit    = 1'b1;
                    cnt_clr = 1'b1;
                    if (rep_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_addr = r_addr + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_lo    <= '0;
            r_hi    <= '0;
            r_addr  <= '0;
        end else begin
            r_state <= n_state;
            r_lo    <= n_lo;
            r_hi    <= n_hi;
            r_addr  <= n_addr;
        end
    end

    // word under search and the end-of-text mark that goes with it
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_key <= lookup.key;
            r_eot <= i_s_axis_tlast;
        end
    end

    // keyword counts; the report clears each entry as it is sent
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                r_cnt[i] <= '0;
            end
            r_nz <= '0;
        end else if (cnt_inc) begin
            r_cnt[rd_addr] <= cnt_rd + 1'b1;
            r_nz[rd_addr]  <= 1'b1;
        end else if (cnt_clr) begin
            r_cnt[rd_addr] <= '0;
            r_nz[rd_addr]  <= 1'b0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit || emit_none) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_idx  <= ckw_pkg::KW_IDX_W'(r_addr);
            r_out_hit  <= (cnt_ext > 32'hFFFF) ? 16'hFFFF : cnt_ext[15:0];
            r_out_none <= 1'b0;
            r_out_last <= rep_last;
        end else if (emit_none) begin
            r_out_idx  <= '0;
            r_out_hit  <= '0;
            r_out_none <= 1'b1;
            r_out_last <= 1'b1;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_out_hit, r_out_idx};
    assign o_m_axis_tuser  = r_out_none;
    assign o_m_axis_tlast  = r_out_last;

    // search range never inverts
    a_range_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> (r_lo <= r_hi))
        else $error("search range inverted");

    // a "none" item is always the last of its report
    a_none_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_none) |-> r_out_last)
        else $error("none item without last mark");

    // the report leaves every count cleared
    a_report_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REPORT && n_state == S_IDLE) |=> (r_nz == '0))
        else $error("counts left after report");

endmodule
